### src/fha_pkg.sv
// fha_pkg: shared state type and q30/q40 constants for the analytic-signal block
// used by the top level, no dependencies
package fha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CONV,
    ST_DRAIN,
    ST_COPY
  } fha_state_t;

  localparam longint unsigned PI_Q40  = 64'd3454217652358;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;
  localparam longint unsigned HALF_Q30 = 64'd536870912;

endpackage

### src/fha_if.sv
// fha_in_if / fha_out_if: valid-ready channels for the analytic-signal block
// no dependencies
interface fha_in_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface fha_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_real;
  logic signed [SAMPLE_BITS-1:0] out_imag;
  modport source (output valid, output out_real, output out_imag, input ready);
  modport sink (input valid, input out_real, input out_imag, output ready);
endinterface

### src/fft_hilbert_analytic_signal.sv
// fft_hilbert_analytic_signal: block hilbert transformer, one complex word out per real word in
// depends on fha_pkg (state type, q30 constants) and fha_if (channels)

// Each real input word is written into an N-entry sample memory (N = BLOCK_SIZE)
// whose first N/4 entries repeat the last N/4 samples of the previous block; each
// accepted word also returns one analytic word read from the result memory.
// Each ordinary word is accepted, then the result memory read is loaded into
// the output register. The word that fills the block then triggers block
// processing: convolution on one dual-read sample memory port pair and one
// multiplier (one odd kernel tap per cycle plus one slot for the real part per
// output), pipeline drain, copying the overlap and the last overlap write; one
// block takes 3N/4 new words.
// Output is zero until the first block is processed; imaginary part is rounded
// half up and saturated.
module fft_hilbert_analytic_signal #(
  parameter int BLOCK_SIZE  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  fha_in_if.sink           in_ch,
  fha_out_if.source        out_ch
);

  localparam int N   = BLOCK_SIZE;
  localparam int Q   = BLOCK_SIZE / 4;
  localparam int SB  = SAMPLE_BITS;
  localparam int NB  = $clog2(N);
  localparam int KB  = $clog2(Q + 1);
  localparam int TB  = $clog2(Q);
  localparam int PW  = SB + 1 + 33;
  localparam int AW  = PW + TB + 1;

  // ---- kernel table (odd taps only), built at elaboration
  // h[m] = 2*cot(pi*m/n)/n in q2.30, sin and cos from 9-term taylor series in q30
  logic [31:0] kern_w [Q];
  for (genvar g = 0; g < Q; g++) begin : g_kern
    localparam longint unsigned NN  = longint'(N);
    localparam longint unsigned MM  = longint'(2 * g + 1);
    localparam longint unsigned HQ  = fha_pkg::HALF_Q30;
    localparam longint unsigned PHI = (MM * fha_pkg::PI_Q40 + NN * 512) / (NN * 1024);
    localparam longint unsigned P2  = (PHI * PHI + HQ) >> 30;
    // sine terms
    localparam longint unsigned S1 = ((PHI * P2 + HQ) >> 30) / 6;
    localparam longint unsigned S2 = ((S1 * P2 + HQ) >> 30) / 20;
    localparam longint unsigned S3 = ((S2 * P2 + HQ) >> 30) / 42;
    localparam longint unsigned S4 = ((S3 * P2 + HQ) >> 30) / 72;
    localparam longint unsigned S5 = ((S4 * P2 + HQ) >> 30) / 110;
    localparam longint unsigned S6 = ((S5 * P2 + HQ) >> 30) / 156;
    localparam longint unsigned S7 = ((S6 * P2 + HQ) >> 30) / 210;
    localparam longint unsigned S8 = ((S7 * P2 + HQ) >> 30) / 272;
    // cosine terms
    localparam longint unsigned C1 = ((fha_pkg::ONE_Q30 * P2 + HQ) >> 30) / 2;
    localparam longint unsigned C2 = ((C1 * P2 + HQ) >> 30) / 12;
    localparam longint unsigned C3 = ((C2 * P2 + HQ) >> 30) / 30;
    localparam longint unsigned C4 = ((C3 * P2 + HQ) >> 30) / 56;
    localparam longint unsigned C5 = ((C4 * P2 + HQ) >> 30) / 90;
    localparam longint unsigned C6 = ((C5 * P2 + HQ) >> 30) / 132;
    localparam longint unsigned C7 = ((C6 * P2 + HQ) >> 30) / 182;
    localparam longint unsigned C8 = ((C7 * P2 + HQ) >> 30) / 240;
    localparam longint SIN_V = longint'(PHI) - longint'(S1) + longint'(S2) - longint'(S3)
                             + longint'(S4) - longint'(S5) + longint'(S6) - longint'(S7)
                             + longint'(S8);
    localparam longint COS_V = longint'(fha_pkg::ONE_Q30) - longint'(C1) + longint'(C2)
                             - longint'(C3) + longint'(C4) - longint'(C5) + longint'(C6)
                             - longint'(C7) + longint'(C8);
    localparam longint unsigned SIN_C = (SIN_V < 1) ? 64'd1 : $unsigned(SIN_V);
    localparam longint unsigned COS_C = (COS_V < 0) ? 64'd0 : $unsigned(COS_V);
    localparam longint unsigned COT   = (COS_C << 30) / SIN_C;
    localparam logic [31:0] COEF = 32'((2 * COT + NN / 2) / NN);
    assign kern_w[g] = COEF;
  end

  // ---- memories
  logic signed [SB-1:0]   smp_mem [N];
  logic [2*SB-1:0]        res_mem [N];

  fha_pkg::fha_state_t state_r, state_nxt;

  logic [NB:0]   fill_r;     // next write position, Q..N
  logic          done_r;     // first block has been processed
  logic [NB-1:0] n_r;        // output index in convolution
  logic [KB-1:0] k_r;        // slot in convolution: 0 = real part, else tap
  logic [KB-1:0] cp_r;       // overlap copy counter

  logic          in_acc;
  logic          out_acc;
  logic          conv_issue;
  logic          copy_issue;

  // sample memory port signals
  logic [NB-1:0] addr_a, addr_b;
  logic [NB-1:0] m_odd;
  logic [NB:0]   sum_b, dif_a;
  logic signed [SB-1:0] rda_q_r, rdb_q_r;
  logic          zra_r, zrb_r;
  logic signed [SB-1:0] xa, xb;

  // result memory read
  logic [2*SB-1:0] res_q_r;
  logic [NB-1:0]   res_addr;

  // convolution pipeline tags
  logic          v1_r, first1_r, last1_r;
  logic [NB-1:0] n1_r;
  logic [TB-1:0] t1_r;
  logic          v2_r, first2_r, last2_r;
  logic [NB-1:0] n2_r;
  logic signed [SB:0]  d2_r;
  logic signed [32:0]  c2_r;
  logic          v3_r, first3_r, last3_r;
  logic [NB-1:0] n3_r;
  logic signed [SB:0]  d3_r;
  logic signed [PW-1:0] prod3_r;
  logic signed [AW-1:0] acc_r;
  logic signed [SB-1:0] real_r;
  logic signed [AW-1:0] acc_sum;
  logic signed [AW-31:0] q_round;
  logic signed [SB-1:0] imag_sat;

  // overlap copy write stage
  logic          cw_v_r;
  logic [NB-1:0] cw_addr_r;

  // output register
  logic                 out_valid_r;
  logic signed [SB-1:0] out_real_r, out_imag_r;

  // ---- handshake
  // the last overlap write still owns the sample memory write port
  assign in_ch.ready     = (state_r == fha_pkg::ST_IDLE) && !cw_v_r &&
                           (!out_valid_r || out_ch.ready);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_real = out_real_r;
  assign out_ch.out_imag = out_imag_r;
  assign out_acc         = out_valid_r && out_ch.ready;

  // ---- control
  always_comb begin
    state_nxt  = state_r;
    conv_issue = 1'b0;
    copy_issue = 1'b0;
    case (state_r)
      fha_pkg::ST_IDLE: begin
        if (in_acc) state_nxt = fha_pkg::ST_LOAD;
      end
      fha_pkg::ST_LOAD: begin
        if (fill_r == (NB+1)'(N)) state_nxt = fha_pkg::ST_CONV;
        else state_nxt = fha_pkg::ST_IDLE;
      end
      fha_pkg::ST_CONV: begin
        conv_issue = 1'b1;
        if (n_r == NB'(N - 1) && k_r == KB'(Q)) state_nxt = fha_pkg::ST_DRAIN;
      end
      fha_pkg::ST_DRAIN: begin
        if (v3_r && last3_r && n3_r == NB'(N - 1)) state_nxt = fha_pkg::ST_COPY;
      end
      fha_pkg::ST_COPY: begin
        copy_issue = (cp_r != KB'(Q));
        if (cp_r == KB'(Q)) state_nxt = fha_pkg::ST_IDLE;
      end
      default: state_nxt = fha_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= fha_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= (NB+1)'(Q);
      done_r <= 1'b0;
      n_r    <= '0;
      k_r    <= '0;
      cp_r   <= '0;
    end else begin
      if (in_acc) fill_r <= fill_r + 1'b1;
      if (conv_issue) begin
        if (k_r == KB'(Q)) begin
          k_r <= '0;
          n_r <= n_r + 1'b1;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
      if (state_r == fha_pkg::ST_DRAIN && state_nxt == fha_pkg::ST_COPY) begin
        done_r <= 1'b1;
        cp_r   <= '0;
      end else if (copy_issue) begin
        cp_r <= cp_r + 1'b1;
      end
      if (state_r == fha_pkg::ST_COPY && state_nxt == fha_pkg::ST_IDLE) begin
        fill_r <= (NB+1)'(Q);
        n_r    <= '0;
      end
    end
  end

  // ---- sample memory addressing, indexes wrap modulo n
  assign m_odd = NB'({k_r, 1'b0}) - NB'(1);
  assign sum_b = {1'b0, n_r} + {1'b0, m_odd};
  assign dif_a = {1'b0, n_r} - {1'b0, m_odd};
  always_comb begin
    addr_a = n_r;
    if (sum_b >= (NB+1)'(N)) addr_b = NB'(sum_b - (NB+1)'(N));
    else addr_b = NB'(sum_b);
    if (copy_issue) addr_a = NB'(N - Q) + NB'(cp_r);
    else if (k_r != '0) begin
      if (dif_a[NB]) addr_a = NB'(dif_a + (NB+1)'(N));
      else addr_a = NB'(dif_a);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) smp_mem[fill_r[NB-1:0]] <= in_ch.sample;
    else if (cw_v_r) smp_mem[cw_addr_r] <= rda_q_r;
    rda_q_r <= smp_mem[addr_a];
    rdb_q_r <= smp_mem[addr_b];
    zra_r   <= !done_r && (addr_a < NB'(Q));
    zrb_r   <= !done_r && (addr_b < NB'(Q));
  end

  // entries 0..Q-1 read as zero until the first overlap copy writes them
  assign xa = zra_r ? '0 : rda_q_r;
  assign xb = zrb_r ? '0 : rdb_q_r;

  // ---- copy write stage
  always_ff @(posedge clk) begin
    if (!rst_n) cw_v_r <= 1'b0;
    else cw_v_r <= copy_issue;
    cw_addr_r <= NB'(cp_r);
  end

  // ---- convolution pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= conv_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    // issue tags
    first1_r <= (k_r == '0);
    last1_r  <= (k_r == KB'(Q));
    n1_r     <= n_r;
    t1_r     <= TB'(k_r - 1'b1);
    // operand stage: real-part slot carries x[n] in the difference lane
    first2_r <= first1_r;
    last2_r  <= last1_r;
    n2_r     <= n1_r;
    if (first1_r) begin
      d2_r <= (SB+1)'(xa);
      c2_r <= '0;
    end else begin
      d2_r <= (SB+1)'(xa) - (SB+1)'(xb);
      c2_r <= {1'b0, kern_w[t1_r]};
    end
    // multiply stage
    first3_r <= first2_r;
    last3_r  <= last2_r;
    n3_r     <= n2_r;
    d3_r     <= d2_r;
    prod3_r  <= PW'(c2_r) * PW'(d2_r);
  end

  assign acc_sum = acc_r + AW'(prod3_r);
  assign q_round = (AW-30)'((acc_sum + AW'(64'sd536870912)) >>> 30);

  always_comb begin
    if (q_round > (AW-30)'((64'sd1 <<< (SB - 1)) - 1)) imag_sat = {1'b0, {(SB-1){1'b1}}};
    else if (q_round < -(AW-30)'(64'sd1 <<< (SB - 1))) imag_sat = {1'b1, {(SB-1){1'b0}}};
    else imag_sat = SB'(q_round);
  end

  always_ff @(posedge clk) begin
    if (v3_r) begin
      if (first3_r) begin
        acc_r  <= '0;
        real_r <= SB'(d3_r);
      end else begin
        acc_r <= acc_sum;
      end
    end
  end

  // ---- result memory
  assign res_addr = NB'(fill_r - (NB+1)'(Q));

  always_ff @(posedge clk) begin
    if (v3_r && last3_r) res_mem[n3_r] <= {real_r, imag_sat};
    res_q_r <= res_mem[res_addr];
  end

  // ---- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == fha_pkg::ST_LOAD) out_valid_r <= 1'b1;
      else if (out_acc) out_valid_r <= 1'b0;
    end
    if (state_r == fha_pkg::ST_LOAD) begin
      // result memory holds nothing valid before the first block
      out_real_r <= done_r ? res_q_r[2*SB-1:SB] : '0;
      out_imag_r <= done_r ? res_q_r[SB-1:0] : '0;
    end
  end

endmodule

### dv/tb.sv
// tb: testbench for fft_hilbert_analytic_signal, checks each analytic word against a predictor
// depends on fha_pkg, fha_if and the block's rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N   = 256;
  localparam int SB  = 16;
  localparam int QTR = N / 4;
  localparam longint unsigned PIQ  = 64'd3454217652358;
  localparam longint          ONEQ = 64'sd1073741824;
  localparam longint          HALFQ = 64'sd536870912;

  typedef struct packed {
    logic signed [SB-1:0] re;
    logic signed [SB-1:0] im;
  } aword_t;

  // analytic signal predictor plus queue of expected output words
  class analytic_scoreboard;
    longint             taps[N/2];
    logic signed [SB-1:0] samples[N];
    aword_t             results[N];
    int                 fill;
    aword_t             pending[$];
    int                 errors;

    function longint unsigned qmul(longint unsigned a, longint unsigned b);
      return (a * b + 64'd536870912) >> 30;
    endfunction

    // cot based tap, taylor sin/cos in q30
    function longint make_tap(int unsigned m);
      longint unsigned phi, p2, term, ct, nn;
      longint sn, cs;
      nn  = N;
      phi = (longint'(m) * PIQ + nn * 512) / (nn * 1024);
      p2  = qmul(phi, phi);
      term = phi;
      sn = phi;
      for (int k = 1; k <= 8; k++) begin
        term = qmul(term, p2) / ((2 * k) * (2 * k + 1));
        if (k % 2) sn -= term;
        else sn += term;
      end
      term = ONEQ;
      cs = ONEQ;
      for (int k = 1; k <= 8; k++) begin
        term = qmul(term, p2) / ((2 * k - 1) * (2 * k));
        if (k % 2) cs -= term;
        else cs += term;
      end
      if (sn < 1) sn = 1;
      if (cs < 0) cs = 0;
      ct = ($unsigned(cs) << 30) / $unsigned(sn);
      return longint'((2 * ct + nn / 2) / nn);
    endfunction

    function new();
      for (int i = 0; i < N; i++) begin
        samples[i] = '0;
        results[i] = '0;
      end
      for (int m = 0; m < N / 2; m++) taps[m] = (m % 2) ? make_tap(m) : 0;
      fill = QTR;
      errors = 0;
    endfunction

    task report(string what, longint want, longint got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
      errors++;
    endtask

    function logic signed [SB-1:0] round_clip(longint acc);
      longint v, q, hi;
      hi = (longint'(1) << (SB - 1)) - 1;
      v = acc + HALFQ;
      if (v >= 0) q = v / ONEQ;
      else q = -((-v + ONEQ - 1) / ONEQ);
      if (q > hi) q = hi;
      if (q < -hi - 1) q = -hi - 1;
      return q[SB-1:0];
    endfunction

    function void run_block();
      longint acc;
      for (int n = 0; n < N; n++) begin
        acc = 0;
        for (int m = 1; m < N / 2; m += 2)
          acc += taps[m] * (longint'(samples[(n + N - m) % N]) - longint'(samples[(n + m) % N]));
        results[n].re = samples[n];
        results[n].im = round_clip(acc);
      end
      for (int n = 0; n < QTR; n++) samples[n] = samples[N - QTR + n];
      fill = QTR;
    endfunction

    function void note_input(logic signed [SB-1:0] x);
      pending.push_back(results[fill - QTR]);
      samples[fill] = x;
      fill++;
      if (fill >= N) run_block();
    endfunction

    task check_result(aword_t got);
      aword_t want;
      if (pending.size() == 0) begin
        report("word with no expectation", 0, got.re);
        return;
      end
      want = pending.pop_front();
      if (got.re !== want.re) report("out_real", want.re, got.re);
      if (got.im !== want.im) report("out_imag", want.im, got.im);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  fha_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
  fha_out_if #(.SAMPLE_BITS(SB)) out_ch ();

  fft_hilbert_analytic_signal #(.BLOCK_SIZE(N), .SAMPLE_BITS(SB)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  analytic_scoreboard sb = new();
  bit recv_stall = 1'b0;

  // one word onto the input channel, held until accepted
  task automatic send_word(logic signed [SB-1:0] x);
    in_ch.valid  <= 1'b1;
    in_ch.sample <= x;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(x);
  endtask

  task automatic gap(int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // draws biased toward the edges, otherwise narrow or full range
  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return SB'($urandom_range(0, 200) - 100);
      3: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
      default: return SB'($urandom);
    endcase
  endfunction

  // receiver: stall pattern with phases of no stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) sb.check_result({out_ch.out_real, out_ch.out_imag});
      out_ch.ready <= recv_stall ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always begin
    repeat ($urandom_range(50, 400)) @(posedge clk);
    recv_stall = ~recv_stall;
  end

  initial begin
    int left;
    in_ch.valid  <= 1'b0;
    in_ch.sample <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, then a square wave completing the block for saturation of the imag part
    send_word(16'sh7fff);
    send_word(16'sh8000);
    send_word(16'sh0000);
    send_word(16'sh0001);
    send_word(16'shffff);
    for (int i = 0; i < 187; i++) send_word(((i / 4) % 2) ? 16'sh8000 : 16'sh7fff);
    // hold off until every expected word has come
    gap(1);
    while (sb.pending.size() != 0) @(posedge clk);
    // random part in bursts
    left = 508;
    while (left > 0) begin
      for (int b = $urandom_range(1, 40); b > 0 && left > 0; b--) begin
        send_word(pick_sample());
        left--;
      end
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 30));
    end
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb failed");
    $finish;
  end
endmodule
